// File: hdl/i2cmbe_pkg.sv
// ----------------------------------------------------------------------------
// i2cmbe_pkg: shared types and constants of the I2C master bit engine
// Command codes, sequence steps, the queued item word and the register set.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  localparam int BITS_PER_BYTE = 8;

  // Front-to-back queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd1;

  localparam logic [15:0] HALF_PERIOD_RST = 16'd250;
  localparam logic [7:0]  ACK_POLLS_RST   = 8'd200;

  typedef enum logic [2:0] {
    CMD_START    = 3'd0,
    CMD_STOP     = 3'd1,
    CMD_WRITE    = 3'd2,
    CMD_READ     = 3'd3,
    CMD_WAIT_ACK = 3'd4,
    CMD_ACK      = 3'd5,
    CMD_NACK     = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    SEQ_S0 = 3'd0,
    SEQ_S1 = 3'd1,
    SEQ_S2 = 3'd2,
    SEQ_S3 = 3'd3,
    SEQ_S4 = 3'd4,
    SEQ_S5 = 3'd5,
    SEQ_S6 = 3'd6
  } step_t;

  // One classified tick as it travels through the queue
  typedef struct packed {
    logic       cmd_start;  // valid command with a defined opcode
    cmd_t       opcode;
    logic [7:0] wbyte;
    logic       sda;
  } item_t;

  typedef struct packed {
    logic [15:0] half_period;
    logic [7:0]  ack_limit;
  } cfg_t;

endpackage

// File: hdl/i2cmbe_front.sv
// ----------------------------------------------------------------------------
// i2cmbe_front: tick intake
// Classifies each incoming tick and parks it in a short queue for the engine.
// ----------------------------------------------------------------------------
module i2cmbe_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd_valid,
  input  logic [2:0]         opcode,
  input  logic [7:0]         write_byte,
  input  logic               sda_in,
  output logic               q_valid,
  output i2cmbe_pkg::item_t  q_item,
  input  logic               q_pop
);
  import i2cmbe_pkg::*;

  item_t             q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  item_t             item_in;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // opcode seven is no command at all
  always_comb begin
    item_in.cmd_start = cmd_valid && (opcode <= 3'(CMD_NACK));
    item_in.opcode    = cmd_t'(opcode);
    item_in.wbyte     = write_byte;
    item_in.sda       = sda_in;
  end

  assign in_stall = (count == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_item   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (q_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/i2cmbe_back.sv
// ----------------------------------------------------------------------------
// i2cmbe_back: bus sequencer and output register
// Plays one tick per cycle through the command sequences, unless stalled.
// ----------------------------------------------------------------------------
module i2cmbe_back (
  input  logic               clk,
  input  logic               rst,
  input  i2cmbe_pkg::cfg_t   cfg,
  input  logic               q_valid,
  input  i2cmbe_pkg::item_t  q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               scl_level,
  output logic               sda_level,
  output logic               sda_enable,
  output logic               busy_res,
  output logic               done_res,
  output logic [7:0]         read_byte,
  output logic               ack_failed
);
  import i2cmbe_pkg::*;

  // sequencer state
  logic        busy, busy_next;
  cmd_t        cmd, cmd_next;
  step_t       step, step_next;
  logic [15:0] delay, delay_next;
  // datapath
  logic [3:0]  bit_idx, bit_idx_next;
  logic [7:0]  shift, shift_next;
  logic [7:0]  poll, poll_next;
  logic        scl, scl_next;
  logic        sda, sda_next;
  logic        sden, sden_next;
  logic [7:0]  rd, rd_next;
  logic        af, af_next;

  logic        run;
  logic        done;
  cmd_t        eff_cmd;
  step_t       eff_step;
  logic [7:0]  poll_inc;
  logic        timeout;
  logic [3:0]  bit_inc;
  logic        more_bits;
  logic        ld;
  step_t       ld_step;

  assign q_pop = q_valid && (!out_valid || !out_stall);

  // A sequence step runs on a new command or when the phase delay expires
  assign run       = busy ? (delay <= 16'd1) : q_item.cmd_start;
  assign eff_cmd   = busy ? cmd : q_item.opcode;
  assign eff_step  = busy ? step : SEQ_S0;
  assign poll_inc  = poll + 8'd1;
  assign timeout   = (poll_inc >= cfg.ack_limit);
  assign bit_inc   = bit_idx + 4'd1;
  assign more_bits = (bit_inc < 4'(BITS_PER_BYTE));

  // Next state: step, command, delay, busy and done
  always_comb begin
    busy_next  = busy;
    cmd_next   = cmd;
    step_next  = step;
    delay_next = delay;
    done       = 1'b0;
    ld         = 1'b0;
    ld_step    = SEQ_S0;

    if (!busy) begin
      if (q_item.cmd_start) begin
        busy_next  = 1'b1;
        cmd_next   = q_item.opcode;
        step_next  = SEQ_S0;
        delay_next = '0;
      end
    end else if (delay > 16'd1) begin
      delay_next = delay - 16'd1;
    end else begin
      delay_next = '0;
    end

    if (run) begin
      unique case (eff_cmd) inside
        CMD_START, CMD_STOP: begin
          unique case (eff_step) inside
            SEQ_S0: begin ld = 1'b1; ld_step = SEQ_S1; end
            SEQ_S1: begin ld = 1'b1; ld_step = SEQ_S2; end
            SEQ_S2: begin ld = 1'b1; ld_step = SEQ_S3; end
            SEQ_S3: begin ld = 1'b1; ld_step = SEQ_S4; end
            SEQ_S4: begin ld = 1'b1; ld_step = SEQ_S5; end
            default: done = 1'b1;
          endcase
        end
        CMD_WRITE: begin
          unique case (eff_step) inside
            SEQ_S0, SEQ_S1: begin ld = 1'b1; ld_step = SEQ_S2; end
            SEQ_S2: begin ld = 1'b1; ld_step = SEQ_S3; end
            SEQ_S3: begin ld = 1'b1; ld_step = SEQ_S4; end
            SEQ_S4: begin ld = 1'b1; ld_step = more_bits ? SEQ_S2 : SEQ_S6; end
            SEQ_S5: begin ld = 1'b1; ld_step = SEQ_S6; end
            default: done = 1'b1;
          endcase
        end
        CMD_READ: begin
          unique case (eff_step) inside
            SEQ_S0, SEQ_S1: begin ld = 1'b1; ld_step = SEQ_S2; end
            SEQ_S2: begin ld = 1'b1; ld_step = SEQ_S3; end
            SEQ_S3: begin ld = 1'b1; ld_step = more_bits ? SEQ_S1 : SEQ_S4; end
            default: done = 1'b1;
          endcase
        end
        CMD_WAIT_ACK: begin
          unique case (eff_step) inside
            SEQ_S0: begin ld = 1'b1; ld_step = SEQ_S1; end
            SEQ_S1: begin ld = 1'b1; ld_step = SEQ_S2; end
            SEQ_S2: begin
              if (!q_item.sda) begin
                ld      = 1'b1;
                ld_step = SEQ_S3;
              end else if (timeout) begin
                // give up: switch to a stop command, skipping to its step S1
                cmd_next = CMD_STOP;
                ld       = 1'b1;
                ld_step  = SEQ_S1;
              end else begin
                step_next = SEQ_S2;  // poll again next tick
              end
            end
            default: done = 1'b1;
          endcase
        end
        CMD_ACK, CMD_NACK: begin
          unique case (eff_step) inside
            SEQ_S0: begin ld = 1'b1; ld_step = SEQ_S1; end
            SEQ_S1: begin ld = 1'b1; ld_step = SEQ_S2; end
            SEQ_S2: begin ld = 1'b1; ld_step = SEQ_S3; end
            default: done = 1'b1;
          endcase
        end
        default: done = 1'b1;
      endcase
    end

    if (ld) begin
      step_next  = ld_step;
      delay_next = cfg.half_period;
    end
    if (done) begin
      busy_next  = 1'b0;
      step_next  = SEQ_S0;
      delay_next = '0;
    end
  end

  // Outputs: line levels, shifter, poll count, read byte, ack flag
  always_comb begin
    bit_idx_next = bit_idx;
    shift_next   = shift;
    poll_next    = poll;
    scl_next     = scl;
    sda_next     = sda;
    sden_next    = sden;
    rd_next      = rd;
    af_next      = af;

    if (run) begin
      unique case (eff_cmd) inside
        CMD_START: begin
          unique case (eff_step) inside
            SEQ_S0: begin sden_next = 1'b1; scl_next = 1'b1; end
            SEQ_S1: sda_next = 1'b1;
            SEQ_S3: sda_next = 1'b0;
            SEQ_S4: scl_next = 1'b0;
            default: ;
          endcase
        end
        CMD_STOP: begin
          unique case (eff_step) inside
            SEQ_S0: begin sden_next = 1'b1; scl_next = 1'b0; end
            SEQ_S1: sda_next = 1'b0;
            SEQ_S2: scl_next = 1'b1;
            SEQ_S3: sda_next = 1'b1;
            default: ;
          endcase
        end
        CMD_WRITE: begin
          unique case (eff_step) inside
            SEQ_S0: begin
              sden_next    = 1'b1;
              shift_next   = q_item.wbyte;
              bit_idx_next = '0;
            end
            SEQ_S2: sda_next = shift[7];
            SEQ_S3: scl_next = 1'b1;
            SEQ_S4: begin
              scl_next     = 1'b0;
              shift_next   = {shift[6:0], 1'b0};
              bit_idx_next = bit_inc;
            end
            default: ;
          endcase
        end
        CMD_READ: begin
          unique case (eff_step) inside
            SEQ_S0: begin
              sden_next    = 1'b0;
              shift_next   = '0;
              bit_idx_next = '0;
            end
            SEQ_S1: ;
            SEQ_S2: scl_next = 1'b1;
            SEQ_S3: begin
              shift_next   = {shift[6:0], q_item.sda};
              scl_next     = 1'b0;
              bit_idx_next = bit_inc;
            end
            default: rd_next = shift;  // command completes
          endcase
        end
        CMD_WAIT_ACK: begin
          unique case (eff_step) inside
            SEQ_S0: begin sden_next = 1'b0; af_next = 1'b0; poll_next = '0; end
            SEQ_S1: scl_next = 1'b1;
            SEQ_S2: begin
              if (!q_item.sda) begin
                scl_next = 1'b0;
              end else begin
                poll_next = poll_inc;
                if (timeout) begin
                  af_next   = 1'b1;
                  sden_next = 1'b1;
                  scl_next  = 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
        CMD_ACK, CMD_NACK: begin
          unique case (eff_step) inside
            SEQ_S0: begin sden_next = 1'b1; sda_next = (eff_cmd == CMD_NACK); end
            SEQ_S1: scl_next = 1'b1;
            SEQ_S2: scl_next = 1'b0;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      cmd     <= CMD_START;
      step    <= SEQ_S0;
      delay   <= '0;
      bit_idx <= '0;
      shift   <= '0;
      poll    <= '0;
      scl     <= 1'b1;
      sda     <= 1'b1;
      sden    <= 1'b0;
      rd      <= '0;
      af      <= 1'b0;
    end else if (q_pop) begin
      busy    <= busy_next;
      cmd     <= cmd_next;
      step    <= step_next;
      delay   <= delay_next;
      bit_idx <= bit_idx_next;
      shift   <= shift_next;
      poll    <= poll_next;
      scl     <= scl_next;
      sda     <= sda_next;
      sden    <= sden_next;
      rd      <= rd_next;
      af      <= af_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      scl_level  <= scl_next;
      sda_level  <= sda_next;
      sda_enable <= sden_next;
      busy_res   <= busy_next;
      done_res   <= done;
      read_byte  <= rd_next;
      ack_failed <= af_next;
    end
  end

endmodule

// File: hdl/i2c_master_bit_engine_core.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core: I2C master bit-level engine
// Each input word is one bus tick; each tick gives one output word with the
// driven SCL/SDA levels and command status.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | word
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_stall  | cmd_valid, opcode, write_byte, sda_in
//  out     | out_valid / out_stall| scl_level, sda_level, sda_enable,
//          |                      | busy_res, done_res, read_byte, ack_failed
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One tick word is taken per cycle, back to back, while in_stall is low;
//  the sequencer retires one tick per cycle unless the output stalls, which sets
//  the rate. A tick passes the queue entry, then the output register.
//  Reset (rst, synchronous) empties the queue, puts the sequencer's line state
//  at idle (SCL and SDA high, SDA released) and loads the default register values.
//  A stalled output holds its word; the two-entry queue absorbs the tick in
//  flight, and in_stall rises only when both entries are full.
//  cfg_ready is always high; the user must see that registers are written
//  only while the engine is idle, as the block itself does not enforce it.
module i2c_master_bit_engine_core (
  input  logic                             clk,
  input  logic                             rst,
  // tick input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             cmd_valid,
  input  logic [2:0]                       opcode,
  input  logic [7:0]                       write_byte,
  input  logic                             sda_in,
  // tick result
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             scl_level,
  output logic                             sda_level,
  output logic                             sda_enable,
  output logic                             busy_res,
  output logic                             done_res,
  output logic [7:0]                       read_byte,
  output logic                             ack_failed,
  // register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [i2cmbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2cmbe_pkg::CFG_DATA_W-1:0] cfg_data
);
  import i2cmbe_pkg::*;

  cfg_t  cfg;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  assign cfg_ready = 1'b1;

  // Register file; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period <= HALF_PERIOD_RST;
      cfg.ack_limit   <= ACK_POLLS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HALF_PERIOD: cfg.half_period <= cfg_data;
        CFG_ACK_TIMEOUT: cfg.ack_limit   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  i2cmbe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd_valid  (cmd_valid),
    .opcode     (opcode),
    .write_byte (write_byte),
    .sda_in     (sda_in),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  i2cmbe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .scl_level  (scl_level),
    .sda_level  (sda_level),
    .sda_enable (sda_enable),
    .busy_res   (busy_res),
    .done_res   (done_res),
    .read_byte  (read_byte),
    .ack_failed (ack_failed)
  );

endmodule

// File: hdl/i2cmbe_checker.sv
// ----------------------------------------------------------------------------
// i2cmbe_checker: port-level checks for the bit engine
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module i2cmbe_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       scl_level,
  input logic       sda_level,
  input logic       sda_enable,
  input logic       busy_res,
  input logic       done_res,
  input logic [7:0] read_byte,
  input logic       ack_failed
);

  // a finished command never reports busy on the same tick
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done_res with busy_res");

  // a free output side drains the queue, so input cannot stay stalled
  a_no_lasting_stall: assert property (@(posedge clk) disable iff (rst)
    !out_stall |=> !in_stall)
    else $error("in_stall while output side free");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(scl_level) && $stable(sda_level)
      && $stable(sda_enable) && $stable(busy_res) && $stable(done_res)
      && $stable(read_byte) && $stable(ack_failed))
    else $error("stalled output word changed");

endmodule

bind i2c_master_bit_engine_core i2cmbe_checker u_chk (.*);
